// File: rtl/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int COUNT_W     = 8;
    localparam int BYTE_W      = 12;
    localparam int OFF_W       = 10;
    localparam int STATUS_W    = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_ASCAN,
        ST_ASPLIT,
        ST_FSCAN,
        ST_FNEXT,
        ST_FMERGE,
        ST_RESP
    } ffba_state_t;

endpackage
`default_nettype wire

// File: rtl/ffba_mod_unit.sv
`default_nettype none
module ffba_mod_unit #(
    parameter int DIVISOR = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [ffba_pkg::BYTE_W-1:0]       operand,
    output logic                                   done,
    output logic [$clog2(DIVISOR):0]               rem
);
    localparam int RW = $clog2(DIVISOR) + 1;

    logic          done_reg;
    logic [RW-1:0] rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    // DIVISOR is a power of two: keep the low operand bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, operand[RW-2:0]};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// File: rtl/first_fit_block_allocator.sv
`default_nettype none
// First-fit block allocator over an arena of ARENA_BYTES bytes.
// Input channel (in_valid/in_stall): command 0 allocates byte_count bytes,
// command 1 frees the block whose payload starts at payload_offset.
// Output channel (out_valid/out_stall): one transaction per request with
// status (0 done, 1 no fit, 2 invalid) and granted_offset (0 unless granted).
// Block headers live in one memory indexed by header byte address; the
// chain is walked one block per cycle through the registered read port.
// A zero count or an out-of-range free goes straight to the response; a
// misaligned free is rejected once the alignment remainder is known. Others
// take the alignment remainder, then walk the chain; an allocate that splits
// writes the split-off free block, a free that is not rejected writes the
// merged block; the last step loads the output register.
// One request is in work at a time; in_stall is high until it is done.
// A finished result waits in the output register while out_stall is high;
// the next request is taken meanwhile, and its result holds until the
// register empties.
// Reset: after rst_n rises, the init state writes the single free block at
// offset zero; in_stall stays high during that state.
module first_fit_block_allocator #(
    parameter int ARENA_BYTES       = 1024,
    parameter int ALIGN_BYTES       = 8,
    parameter int MIN_PAYLOAD_BYTES = 8,
    parameter int HEADER_BYTES      = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              command,
    input  wire logic [ffba_pkg::BYTE_W-1:0]       byte_count,
    input  wire logic [ffba_pkg::OFF_W-1:0]        payload_offset,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [ffba_pkg::STATUS_W-1:0]          status,
    output logic [ffba_pkg::OFF_W-1:0]             granted_offset
);
    import ffba_pkg::*;

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int CW = (AW + 1 > BYTE_W + 1) ? AW + 1 : BYTE_W + 1;
    localparam int RW = $clog2(ALIGN_BYTES) + 1;

    localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] MIN_C   = CW'(MIN_PAYLOAD_BYTES);
    localparam logic [CW-1:0] ALIGN_C = CW'(ALIGN_BYTES);

    // entry: {free, payload size}
    logic [AW:0] mem [0:ARENA_BYTES-1];
    logic [AW:0] rd_data_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW:0]   wr_data;

    ffba_state_t state_reg, state_next;
    logic                 cmd_reg, cmd_next;
    logic [CW-1:0]        need_reg, need_next;
    logic [CW-1:0]        off_reg, off_next;
    logic [AW-1:0]        cur_reg, cur_next;
    logic [AW-1:0]        prev_reg, prev_next;
    logic [AW-1:0]        prev_size_reg, prev_size_next;
    logic                 prev_free_reg, prev_free_next;
    logic                 prev_valid_reg, prev_valid_next;
    logic [CW-1:0]        acc_reg, acc_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [OFF_W-1:0]     res_off_reg, res_off_next;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [OFF_W-1:0]     out_granted_reg;
    logic                 out_load;

    logic                 mod_start;
    logic [BYTE_W-1:0]    mod_operand;
    logic                 mod_done;
    logic [RW-1:0]        mod_rem;

    logic          rd_free;
    logic [CW-1:0] rd_size;
    logic [CW-1:0] cur_c;
    logic [CW-1:0] pay_c;
    logic [CW-1:0] nxt_c;
    logic [CW-1:0] rem_c;
    logic [CW-1:0] split_addr_c;
    logic [CW-1:0] merged_c;
    logic          fit;
    logic          split;

    ffba_mod_unit #(
        .DIVISOR (ALIGN_BYTES)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .operand (mod_operand),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        rd_free      = rd_data_reg[AW];
        rd_size      = CW'(rd_data_reg[AW-1:0]);
        cur_c        = CW'(cur_reg);
        pay_c        = cur_c + HDR_C;
        nxt_c        = pay_c + rd_size;
        rem_c        = CW'(mod_rem);
        split_addr_c = pay_c + need_reg;
        merged_c     = CW'(prev_size_reg) + HDR_C + acc_reg;
        fit          = rd_free && (rd_size >= need_reg);
        split        = (rd_size >= need_reg + HDR_C + MIN_C)
                       && (count_reg < COUNT_W'(TABLE_DEPTH));
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        need_next       = need_reg;
        off_next        = off_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_size_next  = prev_size_reg;
        prev_free_next  = prev_free_reg;
        prev_valid_next = prev_valid_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = '0;
        mod_start       = 1'b0;
        mod_operand     = byte_count;
        out_load        = 1'b0;
        in_stall        = 1'b1;

        case (state_reg)
            ST_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {1'b1, AW'(ARENA_BYTES - HEADER_BYTES)};
                count_next = COUNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_next     = command;
                    need_next    = CW'(byte_count);
                    off_next     = CW'(payload_offset);
                    res_off_next = '0;
                    if (command == CMD_ALLOC)
                    begin
                        mod_operand = byte_count;
                        if (byte_count == '0)
                        begin
                            res_status_next = STAT_INVALID;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            mod_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        mod_operand = BYTE_W'(payload_offset);
                        if ((CW'(payload_offset) < HDR_C) || (CW'(payload_offset) >= ARENA_C))
                        begin
                            res_status_next = STAT_INVALID;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            mod_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    cur_next        = '0;
                    prev_valid_next = 1'b0;
                    rd_addr         = '0;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        need_next  = (mod_rem != '0) ? need_reg + (ALIGN_C - rem_c) : need_reg;
                        rd_en      = 1'b1;
                        state_next = ST_ASCAN;
                    end
                    else if (mod_rem != '0)
                    begin
                        res_status_next = STAT_INVALID;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_FSCAN;
                    end
                end
            end
            ST_ASCAN:
            begin
                if (fit)
                begin
                    res_status_next = STAT_DONE;
                    res_off_next    = pay_c[OFF_W-1:0];
                    wr_en           = 1'b1;
                    wr_addr         = cur_reg;
                    if (split)
                    begin
                        wr_data    = {1'b0, need_reg[AW-1:0]};
                        acc_next   = rd_size - need_reg - HDR_C;
                        count_next = count_reg + 1'b1;
                        state_next = ST_ASPLIT;
                    end
                    else
                    begin
                        wr_data    = {1'b0, rd_data_reg[AW-1:0]};
                        state_next = ST_RESP;
                    end
                end
                else if (nxt_c >= ARENA_C)
                begin
                    res_status_next = STAT_NOFIT;
                    state_next      = ST_RESP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = nxt_c[AW-1:0];
                    cur_next = nxt_c[AW-1:0];
                end
            end
            ST_ASPLIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = split_addr_c[AW-1:0];
                wr_data    = {1'b1, acc_reg[AW-1:0]};
                state_next = ST_RESP;
            end
            ST_FSCAN:
            begin
                if (pay_c == off_reg)
                begin
                    if (rd_free)
                    begin
                        res_status_next = STAT_INVALID;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        acc_next = rd_size;
                        if (nxt_c < ARENA_C)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = nxt_c[AW-1:0];
                            state_next = ST_FNEXT;
                        end
                        else
                        begin
                            state_next = ST_FMERGE;
                        end
                    end
                end
                else if ((pay_c > off_reg) || (nxt_c >= ARENA_C))
                begin
                    res_status_next = STAT_INVALID;
                    state_next      = ST_RESP;
                end
                else
                begin
                    prev_next       = cur_reg;
                    prev_size_next  = rd_data_reg[AW-1:0];
                    prev_free_next  = rd_free;
                    prev_valid_next = 1'b1;
                    cur_next        = nxt_c[AW-1:0];
                    rd_en           = 1'b1;
                    rd_addr         = nxt_c[AW-1:0];
                end
            end
            ST_FNEXT:
            begin
                // absorb the free block that follows
                if (rd_free)
                begin
                    acc_next   = acc_reg + HDR_C + rd_size;
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_FMERGE;
            end
            ST_FMERGE:
            begin
                wr_en           = 1'b1;
                res_status_next = STAT_DONE;
                if (prev_valid_reg && prev_free_reg)
                begin
                    wr_addr    = prev_reg;
                    wr_data    = {1'b1, merged_c[AW-1:0]};
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    wr_addr = cur_reg;
                    wr_data = {1'b1, acc_reg[AW-1:0]};
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // hold until the output register can take the result
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        need_reg       <= need_next;
        off_reg        <= off_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_size_reg  <= prev_size_next;
        prev_free_reg  <= prev_free_next;
        prev_valid_reg <= prev_valid_next;
        acc_reg        <= acc_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_off_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_offset = out_granted_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("block count above table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_DIV))
        else $error("remainder result outside divide phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ASCAN || state_reg == ST_FSCAN) |-> (count_reg != '0))
        else $error("chain walk with empty block table");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == ST_RESP && (!out_valid_reg || !out_stall)))
        else $error("result overwrote a stalled output");

endmodule
`default_nettype wire
